[rtl/core/pidsic_pkg.sv]
package pidsic_pkg;

    localparam int DataW = 32;
    localparam int GainW = 24;
    localparam int LimW  = 31;
    localparam int AddrW = 5;
    localparam int FracW = 16;
    localparam int DiffW = DataW + 1;
    localparam int ProdW = GainW + 1 + DiffW;
    localparam int AccW  = ProdW + 2;

    localparam logic [LimW-1:0] LimReset = 31'd13107200;

    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_LIM  = 3'd3,
        REG_MODE = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [GainW-1:0] kp;
        logic [GainW-1:0] ki;
        logic [GainW-1:0] kd;
        logic [LimW-1:0]  lim;
        logic             clamp;
    } cfg_t;

    typedef struct packed {
        logic signed [DataW-1:0] e;
        logic signed [DiffW-1:0] d;
        logic signed [DiffW-1:0] s;
    } terms_t;

endpackage

[rtl/core/pidsic_cfg.sv]
module pidsic_cfg
    import pidsic_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp    <= '0;
            cfg_reg.ki    <= '0;
            cfg_reg.kd    <= '0;
            cfg_reg.lim   <= LimReset;
            cfg_reg.clamp <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_KP:   cfg_reg.kp    <= pwdata[GainW-1:0];
                REG_KI:   cfg_reg.ki    <= pwdata[GainW-1:0];
                REG_KD:   cfg_reg.kd    <= pwdata[GainW-1:0];
                REG_LIM:  cfg_reg.lim   <= pwdata[LimW-1:0];
                REG_MODE: cfg_reg.clamp <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KP:   prdata = {{(32-GainW){1'b0}}, cfg_reg.kp};
            REG_KI:   prdata = {{(32-GainW){1'b0}}, cfg_reg.ki};
            REG_KD:   prdata = {{(32-GainW){1'b0}}, cfg_reg.kd};
            REG_LIM:  prdata = {{(32-LimW){1'b0}}, cfg_reg.lim};
            REG_MODE: prdata = {31'd0, cfg_reg.clamp};
            default:  prdata = '0;
        endcase
    end

endmodule

[rtl/core/pidsic_state.sv]
module pidsic_state
    import pidsic_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [DataW-1:0] setpoint,
    input  logic signed [DataW-1:0] measured,
    output logic                    terms_valid,
    input  logic                    terms_ready,
    output terms_t                  terms
);

    logic                    smp_valid_reg;
    logic signed [DataW-1:0] sp_reg;
    logic signed [DataW-1:0] ms_reg;
    logic                    mid_valid_reg;
    terms_t                  terms_reg;
    logic signed [DataW-1:0] prev_err_reg;
    logic signed [DataW-1:0] err_sum_reg;

    logic                    smp_ready;
    logic                    mid_ready;
    logic                    advance;
    logic signed [DiffW-1:0] err_wide;
    logic signed [DataW-1:0] err;
    logic signed [DiffW-1:0] diff;
    logic signed [DiffW-1:0] sum;
    logic signed [DiffW-1:0] lim_pos;
    logic signed [DiffW-1:0] lim_neg;
    logic signed [DataW-1:0] err_sum_next;

    assign mid_ready   = !mid_valid_reg || terms_ready;
    assign smp_ready   = !smp_valid_reg || mid_ready;
    assign advance     = smp_valid_reg && mid_ready;
    assign in_ready    = smp_ready;
    assign terms_valid = mid_valid_reg;
    assign terms       = terms_reg;

    always_comb
    begin
        err_wide = {sp_reg[DataW-1], sp_reg} - {ms_reg[DataW-1], ms_reg};
        if (err_wide[DataW] != err_wide[DataW-1])
            err = err_wide[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        else
            err = err_wide[DataW-1:0];

        diff    = {err[DataW-1], err} - {prev_err_reg[DataW-1], prev_err_reg};
        sum     = {err_sum_reg[DataW-1], err_sum_reg} + {err[DataW-1], err};
        lim_pos = {{(DiffW-LimW){1'b0}}, cfg.lim};
        lim_neg = -lim_pos;

        if (cfg.clamp)
        begin
            priority if (sum > lim_pos)
                err_sum_next = lim_pos[DataW-1:0];
            else if (sum < lim_neg)
                err_sum_next = lim_neg[DataW-1:0];
            else
                err_sum_next = sum[DataW-1:0];
        end
        else if (sum[DataW] != sum[DataW-1])
            err_sum_next = sum[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        else
            err_sum_next = sum[DataW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            mid_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            err_sum_reg   <= '0;
        end
        else
        begin
            if (smp_ready)
                smp_valid_reg <= in_valid;
            if (mid_ready)
                mid_valid_reg <= smp_valid_reg;
            if (advance)
            begin
                prev_err_reg <= err;
                err_sum_reg  <= err_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_ready && in_valid)
        begin
            sp_reg <= setpoint;
            ms_reg <= measured;
        end
        if (advance)
        begin
            terms_reg.e <= err;
            terms_reg.d <= diff;
            terms_reg.s <= sum;
        end
    end

endmodule

[rtl/core/pidsic_mac.sv]
module pidsic_mac
    import pidsic_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    terms_valid,
    output logic                    terms_ready,
    input  terms_t                  terms,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DataW-1:0] drive,
    output logic signed [DataW-1:0] error_now,
    output logic                    drive_saturated
);

    logic                    prod_valid_reg;
    logic signed [ProdW-1:0] pp_reg;
    logic signed [ProdW-1:0] pi_reg;
    logic signed [ProdW-1:0] pd_reg;
    logic signed [DataW-1:0] perr_reg;
    logic                    res_valid_reg;
    logic signed [DataW-1:0] drive_reg;
    logic signed [DataW-1:0] err_reg;
    logic                    sat_reg;

    logic                    prod_ready;
    logic                    res_ready;
    logic signed [GainW:0]   kp_s;
    logic signed [GainW:0]   ki_s;
    logic signed [GainW:0]   kd_s;
    logic signed [AccW-1:0]  acc;
    logic signed [AccW-1:0]  scaled;
    logic [AccW-DataW:0]     hi_bits;
    logic                    sat_next;
    logic signed [DataW-1:0] drive_next;

    assign res_ready       = !res_valid_reg || out_ready;
    assign prod_ready      = !prod_valid_reg || res_ready;
    assign terms_ready     = prod_ready;
    assign out_valid       = res_valid_reg;
    assign drive           = drive_reg;
    assign error_now       = err_reg;
    assign drive_saturated = sat_reg;

    assign kp_s = {1'b0, cfg.kp};
    assign ki_s = {1'b0, cfg.ki};
    assign kd_s = {1'b0, cfg.kd};

    always_comb
    begin
        acc = AccW'(pp_reg) + AccW'(pi_reg) + AccW'(pd_reg)
            + (AccW'(1) <<< (FracW - 1));
        scaled  = acc >>> FracW;
        hi_bits = scaled[AccW-1:DataW-1];
        sat_next = !((&hi_bits) || !(|hi_bits));
        if (sat_next)
            drive_next = scaled[AccW-1] ? {1'b1, {(DataW-1){1'b0}}}
                                        : {1'b0, {(DataW-1){1'b1}}};
        else
            drive_next = scaled[DataW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= terms_valid;
            if (res_ready)
                res_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && terms_valid)
        begin
            pp_reg   <= ProdW'(kp_s) * ProdW'(terms.e);
            pi_reg   <= ProdW'(ki_s) * ProdW'(terms.s);
            pd_reg   <= ProdW'(kd_s) * ProdW'(terms.d);
            perr_reg <= terms.e;
        end
        if (res_ready && prod_valid_reg)
        begin
            drive_reg <= drive_next;
            err_reg   <= perr_reg;
            sat_reg   <= sat_next;
        end
    end

endmodule

[rtl/core/pid_step_integral_clamp_core.sv]
// Throughput: one item per cycle unless m_axis_tready stalls the output.
// Stages: input register, error/state stage, multiply stage, sum/round/saturate register.
// Reset (rst_n low, asynchronous): pipeline emptied, previous error and error sum zero,
// gains zero, integral limit 200.0, clamp mode on.
module pid_step_integral_clamp_core
    import pidsic_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // setpoint[31:0], measured[63:32]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // drive[31:0], error_now[63:32]
    output logic [0:0]       m_axis_tuser,   // drive_saturated[0]
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t                    cfg;
    terms_t                  terms;
    logic                    terms_valid;
    logic                    terms_ready;
    logic signed [DataW-1:0] drive;
    logic signed [DataW-1:0] error_now;
    logic                    drive_saturated;

    pidsic_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidsic_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .setpoint    (s_axis_tdata[31:0]),
        .measured    (s_axis_tdata[63:32]),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms)
    );

    pidsic_mac u_mac (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .terms_valid     (terms_valid),
        .terms_ready     (terms_ready),
        .terms           (terms),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .drive           (drive),
        .error_now       (error_now),
        .drive_saturated (drive_saturated)
    );

    assign m_axis_tdata = {error_now, drive};
    assign m_axis_tuser = drive_saturated;

endmodule

[rtl/core/pidsic_checker.sv]
module pidsic_checker
    import pidsic_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [63:0]      m_axis_tdata,
    input logic [0:0]       m_axis_tuser,
    input logic             psel,
    input logic             pwrite,
    input logic [AddrW-1:0] paddr,
    input logic [31:0]      prdata
);

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
            inflight_next = inflight_reg + 3'd1;
        else if (out_xfer && !in_xfer)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[31:0] == 32'h7fff_ffff || m_axis_tdata[31:0] == 32'h8000_0000))
        else $error("saturation flag without limit value");

    a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more items in flight than pipeline stages");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 3'd0)
        else $error("result with no item in flight");

    a_mode_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && paddr[AddrW-1:2] == REG_MODE |-> prdata[31:1] == 31'd0)
        else $error("clamp mode readback wider than one bit");

endmodule

bind pid_step_integral_clamp_core pidsic_checker u_pidsic_checker (.*);
